/* sv/dmsp_pkg.sv */
// ----------------------------------------------------------------------------
// dmsp_pkg: shared types and constants for the dual motor speed PID core
// Field widths, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package dmsp_pkg;

  localparam int unsigned WindowLen  = 10;
  localparam int unsigned MaxPulseUs = 5000;
  localparam int unsigned PulseW     = 13;
  localparam int unsigned SpeedW     = 23;
  localparam int unsigned GainW      = 16;
  localparam int unsigned DriveW     = 8;
  localparam int unsigned IntegW     = 48;
  localparam int unsigned PosW       = $clog2(WindowLen);
  localparam int unsigned FillW      = $clog2(WindowLen + 1);
  localparam int unsigned SumW       = PulseW + FillW;
  // Dividend 5000000*fill: 23 + 4 bits.
  localparam int unsigned NumW       = 27;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 23;
  // PID accumulator width: 48-bit integrator plus headroom for P, D, *255.
  localparam int unsigned AccW       = 60;
  localparam int unsigned DivCntW    = 6;

  localparam logic [NumW-1:0]   SpeedNum   = NumW'(5000000);
  localparam logic [SpeedW-1:0] SpeedMax   = SpeedW'(5000000);
  localparam logic [AccW-1:0]   FullScale  = AccW'(22000 * 4096);
  localparam logic signed [IntegW-1:0] IntegMax = {1'b0, {(IntegW-1){1'b1}}};
  localparam logic signed [IntegW-1:0] IntegMin = {1'b1, {(IntegW-1){1'b0}}};

  typedef enum logic [CfgIdxW-1:0] {
    REG_TARGET = 3'd0,
    REG_PGAIN  = 3'd1,
    REG_IGAIN  = 3'd2,
    REG_DGAIN  = 3'd3,
    REG_RUN    = 3'd4,
    REG_MANUAL = 3'd5
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SUM, ST_SDIV, ST_MUL, ST_PID, ST_DDIV, ST_DONE, ST_OUT
  } state_e;

endpackage

/* sv/dmsp_if.sv */
// ----------------------------------------------------------------------------
// Stream and config interfaces
// Valid/ready channels for pulse items, result items and register writes.
// ----------------------------------------------------------------------------
interface dmsp_in_if;
  import dmsp_pkg::*;
  logic              valid;
  logic              ready;
  logic [PulseW-1:0] pulse_front;
  logic [PulseW-1:0] pulse_back;
  modport source (output valid, pulse_front, pulse_back, input ready);
  modport sink   (input valid, pulse_front, pulse_back, output ready);
endinterface

interface dmsp_out_if;
  import dmsp_pkg::*;
  logic              valid;
  logic              ready;
  logic [DriveW-1:0] drive_front;
  logic [DriveW-1:0] drive_back;
  logic [SpeedW-1:0] speed_front;
  logic [SpeedW-1:0] speed_back;
  modport source (output valid, drive_front, drive_back, speed_front, speed_back,
                  input ready);
  modport sink   (input valid, drive_front, drive_back, speed_front, speed_back,
                  output ready);
endinterface

interface dmsp_cfg_if;
  import dmsp_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* sv/dmsp_divider.sv */
// ----------------------------------------------------------------------------
// dmsp_divider: unsigned restoring divider, one quotient bit per cycle
// Shared by the speed division and the drive scaling.
// ----------------------------------------------------------------------------
module dmsp_divider
  import dmsp_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [AccW-1:0] num_i,
  input  logic [AccW-1:0] den_i,
  output logic            done_o,
  output logic [AccW-1:0] quot_o
);

  logic [AccW-1:0]    rem_q, rem_d, quo_q, quo_d, den_q;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d, done_q, done_d;
  logic [AccW:0]      trial;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[AccW-1]} - {1'b0, den_q};
    if (start_i) begin
      rem_d  = '0;
      quo_d  = num_i;
      cnt_d  = DivCntW'(AccW - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[AccW]) begin
        rem_d = trial[AccW-1:0];
        quo_d = {quo_q[AccW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[AccW-2:0], quo_q[AccW-1]};
        quo_d = {quo_q[AccW-2:0], 1'b0};
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) den_q <= den_i;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

/* sv/dual_motor_speed_pid_core.sv */
// ----------------------------------------------------------------------------
// dual_motor_speed_pid_core: two-channel motor speed PID controller
// Moving-window speed estimate and PID drive for front and back motors.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  carries one item of two encoder pulse widths (0 = timeout, widths
//   above 5000 us count as timeouts). out_if returns one item per input with
//   both drive duties and both speeds. cfg_if writes registers by index:
//   0 target, 1..3 gains (Q4.12), 4 run, 5 manual drive; other indexes are
//   dropped. Writing target or run clears integrators and held drives.
// Timing:
//   One item at a time. A sequencer shares one bit-serial divider and one
//   25x17 multiply per PID term: a sum over the window entries (1..10),
//   2 speed divisions, 3 terms per channel and 2 drive divisions. With run
//   clear the PID terms and drive divisions are skipped.
//   in ready and cfg ready are high only while the sequencer is idle.
// Reset:
//   Registers go to their defaults, window fill and position to 0.
//   Window entries are undefined until written and are never read before.
// Stall:
//   A result waits in the output register until out ready is high; the next
//   item is worked meanwhile and holds in its last state until the register
//   is free.
// ----------------------------------------------------------------------------
module dual_motor_speed_pid_core
  import dmsp_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  dmsp_in_if.sink       in_if,
  dmsp_out_if.source    out_if,
  dmsp_cfg_if.sink      cfg_if
);

  // configuration
  logic [SpeedW-1:0] target_q;
  logic [GainW-1:0]  pgain_q, igain_q, dgain_q;
  logic              run_q;
  logic [DriveW-1:0] manual_q;

  // window storage
  logic [PulseW-1:0] win_f_q [WindowLen];
  logic [PulseW-1:0] win_b_q [WindowLen];
  logic [PosW-1:0]   pos_q;
  logic [FillW-1:0]  fill_q;

  // loop state
  logic signed [IntegW-1:0] integ_q [2];
  logic [SpeedW-1:0]        prev_q [2];
  logic [DriveW-1:0]        held_q [2];

  // working registers
  state_e            state_q, state_d;
  logic [PosW-1:0]   idx_q;
  logic [SumW-1:0]   sum_q [2];
  logic [SpeedW-1:0] spd_q [2];
  logic              ch_q;      // channel under work
  logic [1:0]        term_q;    // 0 P, 1 I, 2 D
  logic signed [AccW-1:0] acc_q;
  logic signed [AccW-1:0] prod_q;
  logic              div_start;
  logic              div_done;
  logic [AccW-1:0]   div_num, div_den, div_quot;
  logic              neg_q;

  // output register
  logic              ovalid_q;
  logic [DriveW-1:0] odf_q, odb_q;
  logic [SpeedW-1:0] osf_q, osb_q;

  logic in_fire, cfg_fire, out_fire, out_free;
  assign in_fire  = in_if.valid && in_if.ready;
  assign cfg_fire = cfg_if.valid && cfg_if.ready;
  assign out_fire = out_if.valid && out_if.ready;
  // output register can take a new result this cycle
  assign out_free = !ovalid_q || out_if.ready;
  assign in_if.ready  = (state_q == ST_IDLE);
  assign cfg_if.ready = (state_q == ST_IDLE);

  dmsp_divider u_div (
    .clk_i, .rst_ni,
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // signed operands of the PID multiply for the current term
  logic signed [SpeedW+1:0] opnd;
  logic [GainW-1:0]         gain;
  always_comb begin
    unique case (term_q)
      2'd0:    begin
        opnd = $signed({2'b00, target_q}) - $signed({2'b00, spd_q[ch_q]});
        gain = pgain_q;
      end
      2'd1:    begin
        opnd = $signed({2'b00, target_q}) - $signed({2'b00, spd_q[ch_q]});
        gain = igain_q;
      end
      default: begin
        opnd = $signed({2'b00, prev_q[ch_q]}) - $signed({2'b00, spd_q[ch_q]});
        gain = dgain_q;
      end
    endcase
  end

  // saturated integrator update
  logic signed [IntegW+1:0] isum;
  logic signed [IntegW-1:0] inew;
  assign isum = $signed({{2{integ_q[ch_q][IntegW-1]}}, integ_q[ch_q]})
              + $signed(prod_q[IntegW+1:0]);
  always_comb begin
    if (isum > $signed({{2{IntegMax[IntegW-1]}}, IntegMax}))      inew = IntegMax;
    else if (isum < $signed({{2{IntegMin[IntegW-1]}}, IntegMin})) inew = IntegMin;
    else                                                          inew = isum[IntegW-1:0];
  end

  // P+I+D including the D product, then *255 magnitude for the drive division
  logic signed [AccW-1:0] acc_nxt;
  logic signed [AccW-1:0] scaled;
  logic [AccW-1:0]        mag;
  assign acc_nxt = acc_q + prod_q;
  assign scaled  = (acc_nxt <<< 8) - acc_nxt;
  assign mag     = scaled[AccW-1] ? AccW'(-scaled) : AccW'(scaled);

  // divider operands; the first speed division starts on the last sum cycle,
  // so its divisor adds the entry read in that cycle
  always_comb begin
    if (state_q == ST_SUM) begin
      div_num = AccW'(SpeedNum * NumW'(fill_q));
      div_den = AccW'(sum_q[0] + SumW'(win_f_q[idx_q]));
    end else if (state_q == ST_SDIV) begin
      div_num = AccW'(SpeedNum * NumW'(fill_q));
      div_den = AccW'(sum_q[1]);
    end else begin
      div_num = mag;
      div_den = FullScale;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_fire) state_d = ST_SUM;
      ST_SUM:  if (idx_q == PosW'(fill_q - 1'b1)) state_d = ST_SDIV;
      ST_SDIV: if (div_done && ch_q) state_d = run_q ? ST_MUL : ST_DONE;
      ST_MUL:  state_d = ST_PID;
      ST_PID:  state_d = (term_q == 2'd2) ? ST_DDIV : ST_MUL;
      ST_DDIV: if (div_done) state_d = ch_q ? ST_DONE : ST_MUL;
      ST_DONE: state_d = ST_OUT;
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // divider launch: on last sum cycle, after first speed quotient,
  // and after the D term of each channel
  always_comb begin
    div_start = 1'b0;
    unique case (state_q)
      ST_SUM:  div_start = (idx_q == PosW'(fill_q - 1'b1));
      ST_SDIV: div_start = div_done && !ch_q;
      ST_PID:  div_start = (term_q == 2'd2);
      default: div_start = 1'b0;
    endcase
  end

  function automatic logic [SpeedW-1:0] sat_speed(input logic [AccW-1:0] q,
                                                  input logic [SumW-1:0] s);
    if (s == '0)                    return '0;
    if (q > AccW'(SpeedMax))        return SpeedMax;
    return q[SpeedW-1:0];
  endfunction

  logic [PulseW-1:0] pf, pb;
  assign pf = (in_if.pulse_front > PulseW'(MaxPulseUs)) ? '0 : in_if.pulse_front;
  assign pb = (in_if.pulse_back  > PulseW'(MaxPulseUs)) ? '0 : in_if.pulse_back;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= SpeedW'(10000);
      pgain_q  <= GainW'(2867);
      igain_q  <= GainW'(369);
      dgain_q  <= '0;
      run_q    <= 1'b0;
      manual_q <= '0;
      pos_q    <= '0;
      fill_q   <= '0;
      integ_q[0] <= '0; integ_q[1] <= '0;
      prev_q[0]  <= '0; prev_q[1]  <= '0;
      held_q[0]  <= '0; held_q[1]  <= '0;
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
      idx_q    <= '0;
      ch_q     <= 1'b0;
      term_q   <= '0;
    end else begin
      state_q <= state_d;
      if (out_fire && state_q != ST_OUT) ovalid_q <= 1'b0;

      if (cfg_fire) begin
        unique case (cfg_if.index)
          REG_TARGET: target_q <= cfg_if.data;
          REG_PGAIN:  pgain_q  <= cfg_if.data[GainW-1:0];
          REG_IGAIN:  igain_q  <= cfg_if.data[GainW-1:0];
          REG_DGAIN:  dgain_q  <= cfg_if.data[GainW-1:0];
          REG_RUN:    run_q    <= cfg_if.data[0];
          REG_MANUAL: manual_q <= cfg_if.data[DriveW-1:0];
          default: ;
        endcase
        if (cfg_if.index == REG_TARGET || cfg_if.index == REG_RUN) begin
          integ_q[0] <= '0; integ_q[1] <= '0;
          held_q[0]  <= '0; held_q[1]  <= '0;
        end
      end

      unique case (state_q)
        ST_IDLE: if (in_fire) begin
          if (fill_q != FillW'(WindowLen)) fill_q <= fill_q + 1'b1;
          pos_q <= (pos_q == PosW'(WindowLen - 1)) ? '0 : pos_q + 1'b1;
          idx_q <= '0;
          ch_q  <= 1'b0;
        end
        ST_SUM:  idx_q <= idx_q + 1'b1;
        ST_SDIV: if (div_done) begin
          ch_q   <= ~ch_q;
          term_q <= '0;
        end
        ST_PID: begin
          if (term_q == 2'd1) integ_q[ch_q] <= inew;
          term_q <= term_q + 1'b1;
        end
        ST_DDIV: if (div_done) begin
          held_q[ch_q] <= neg_q ? '0 :
                          (div_quot > AccW'(255)) ? DriveW'(255) : div_quot[DriveW-1:0];
          ch_q   <= ~ch_q;
          term_q <= '0;
        end
        ST_DONE: if (run_q) manual_q <= '0;
        ST_OUT: if (out_free) begin
          ovalid_q <= 1'b1;
          if (manual_q == '0) begin
            prev_q[0] <= spd_q[0];
            prev_q[1] <= spd_q[1];
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers without reset
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      win_f_q[pos_q] <= pf;
      win_b_q[pos_q] <= pb;
      sum_q[0] <= '0;
      sum_q[1] <= '0;
    end
    // sum reads the entry just written through the input path
    if (state_q == ST_SUM) begin
      sum_q[0] <= sum_q[0] + SumW'(win_f_q[idx_q]);
      sum_q[1] <= sum_q[1] + SumW'(win_b_q[idx_q]);
    end
    if (state_q == ST_SDIV && div_done)
      spd_q[ch_q] <= sat_speed(div_quot, sum_q[ch_q]);
    if (state_q == ST_MUL)
      prod_q <= AccW'(opnd * $signed({1'b0, gain}));
    if (state_q == ST_PID) begin
      unique case (term_q)
        2'd0:    acc_q <= prod_q;
        2'd1:    acc_q <= acc_q + AccW'(inew);
        default: acc_q <= acc_nxt;
      endcase
    end
    if (state_q == ST_PID && term_q == 2'd2)
      neg_q <= acc_nxt < 0;
    if (state_q == ST_OUT && out_free) begin
      odf_q <= (manual_q == '0) ? held_q[0] : manual_q;
      odb_q <= (manual_q == '0) ? held_q[1] : manual_q;
      osf_q <= spd_q[0];
      osb_q <= spd_q[1];
    end
  end

  assign out_if.valid       = ovalid_q;
  assign out_if.drive_front = odf_q;
  assign out_if.drive_back  = odb_q;
  assign out_if.speed_front = osf_q;
  assign out_if.speed_back  = osb_q;

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb: regression bench for the dual motor speed PID core
// Drives pulse items and register writes through the channel interfaces,
// predicts every result from a behavioral model and checks each field.
// ----------------------------------------------------------------------------
module tb;
  import dmsp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [PulseW-1:0] front;
    logic [PulseW-1:0] back;
  } pulse_t;

  typedef struct packed {
    logic [DriveW-1:0] drv_f;
    logic [DriveW-1:0] drv_b;
    logic [SpeedW-1:0] spd_f;
    logic [SpeedW-1:0] spd_b;
  } ctrl_t;

  localparam longint IMax = 64'sh7FFF_FFFF_FFFF;
  localparam longint IMin = -IMax - 1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  dmsp_in_if  in_if ();
  dmsp_out_if out_if ();
  dmsp_cfg_if cfg_if ();

  dual_motor_speed_pid_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source),
    .cfg_if (cfg_if.sink)
  );

  always #1 clk_i = ~clk_i;

  // Model state
  longint unsigned m_target, m_kp, m_ki, m_kd, m_run, m_manual;
  longint unsigned win_f [WindowLen];
  longint unsigned win_b [WindowLen];
  int unsigned     w_pos, w_fill;
  longint          integ_f, integ_b;
  longint unsigned prev_f, prev_b, held_f, held_b;

  pulse_t pulse_q [$];
  ctrl_t  ctrl_q [$];
  int     errors = 0;
  int     in_idle_pct = 0;
  int     out_stall_pct = 0;
  bit     hold_req = 1'b0;
  bit     holding = 1'b0;
  bit     feeding = 1'b0;
  bit     took = 1'b0;

  function automatic longint unsigned rpm_of(ref longint unsigned w [WindowLen]);
    longint unsigned sum, q;
    sum = 0;
    for (int i = 0; i < w_fill; i++) sum += w[i];
    if (sum == 0) return 0;
    q = (64'd5000000 * w_fill) / sum;
    return (q > 5000000) ? 5000000 : q;
  endfunction

  function automatic longint unsigned pid_duty(longint unsigned rpm, longint unsigned prv,
                                               ref longint integ);
    longint err, p, i, d, q;
    err = longint'(m_target) - longint'(rpm);
    p = err * longint'(m_kp);
    i = integ + err * longint'(m_ki);
    d = (longint'(prv) - longint'(rpm)) * longint'(m_kd);
    if (i > IMax) i = IMax;
    if (i < IMin) i = IMin;
    integ = i;
    q = ((p + i + d) * 255) / (22000 * 4096);
    if (q < 0) return 0;
    if (q > 255) return 255;
    return q;
  endfunction

  function automatic ctrl_t predict_ctrl(pulse_t it);
    longint unsigned pf, pb, rf, rb;
    ctrl_t r;
    pf = (it.front > MaxPulseUs) ? 0 : it.front;
    pb = (it.back > MaxPulseUs) ? 0 : it.back;
    win_f[w_pos] = pf;
    win_b[w_pos] = pb;
    if (w_fill < WindowLen) w_fill++;
    rf = rpm_of(win_f);
    rb = rpm_of(win_b);
    w_pos = (w_pos + 1) % WindowLen;
    if (m_run != 0) begin
      m_manual = 0;
      held_f = pid_duty(rf, prev_f, integ_f);
      held_b = pid_duty(rb, prev_b, integ_b);
    end
    if (m_manual == 0) begin
      r.drv_f = DriveW'(held_f);
      r.drv_b = DriveW'(held_b);
      prev_f = rf;
      prev_b = rb;
    end else begin
      r.drv_f = DriveW'(m_manual);
      r.drv_b = DriveW'(m_manual);
    end
    r.spd_f = SpeedW'(rf);
    r.spd_b = SpeedW'(rb);
    return r;
  endfunction

  function automatic void model_write(logic [CfgIdxW-1:0] idx, longint unsigned v);
    case (idx)
      REG_TARGET: begin
        m_target = v & 23'h7FFFFF;
        integ_f = 0; integ_b = 0; held_f = 0; held_b = 0;
      end
      REG_PGAIN:  m_kp = v & 16'hFFFF;
      REG_IGAIN:  m_ki = v & 16'hFFFF;
      REG_DGAIN:  m_kd = v & 16'hFFFF;
      REG_RUN: begin
        m_run = v & 1;
        integ_f = 0; integ_b = 0; held_f = 0; held_b = 0;
      end
      REG_MANUAL: m_manual = v & 8'hFF;
      default: ;
    endcase
  endfunction

  // The model predicts at the accepting edge, in item order.
  always @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      ctrl_q.push_back(predict_ctrl({in_if.pulse_front, in_if.pulse_back}));
    end
  end

  // acceptance seen at the last rising edge
  always @(posedge clk_i) took <= in_if.valid && in_if.ready;

  // Driver: a taken item leaves the queue before the next head is offered.
  always @(negedge clk_i) begin
    if (took) void'(pulse_q.pop_front());
    if (!feeding || !rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (in_if.valid && !took) begin
      in_if.valid <= 1'b1;
    end else if (pulse_q.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
      in_if.valid       <= 1'b1;
      in_if.pulse_front <= pulse_q[0].front;
      in_if.pulse_back  <= pulse_q[0].back;
    end else begin
      in_if.valid <= 1'b0;
    end
  end

  // Long hold-off stretch, counted in cycles.
  always @(hold_req) begin
    holding = 1'b1;
    repeat (3000) @(posedge clk_i);
    holding = 1'b0;
  end

  // Receiver with random stalls.
  always @(negedge clk_i) begin
    if (holding) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    ctrl_t got, exp_r;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = {out_if.drive_front, out_if.drive_back, out_if.speed_front, out_if.speed_back};
      if (ctrl_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
      end else begin
        exp_r = ctrl_q.pop_front();
        if (got !== exp_r) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: drive %0d/%0d speed %0d/%0d, expected %0d/%0d %0d/%0d",
                     got.drv_f, got.drv_b, got.spd_f, got.spd_b,
                     exp_r.drv_f, exp_r.drv_b, exp_r.spd_f, exp_r.spd_b);
        end
      end
    end
  end

  task automatic wait_drained();
    while (pulse_q.size() > 0 || in_if.valid) @(posedge clk_i);
    while (ctrl_q.size() > 0) @(posedge clk_i);
    feeding = 1'b0;
  endtask

  task automatic reg_write(logic [CfgIdxW-1:0] idx, longint unsigned v);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= CfgDataW'(v);
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    model_write(idx, v);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [PulseW-1:0] rand_pulse();
    case ($urandom_range(9))
      0: return '0;
      1: return PulseW'($urandom_range(8191, 5001));
      2: return PulseW'($urandom_range(20, 1));
      3: return PulseW'(5000);
      default: return PulseW'($urandom_range(4000, 200));
    endcase
  endfunction

  task automatic run_phase(int n, int idle, int stall);
    in_idle_pct = idle;
    out_stall_pct = stall;
    for (int i = 0; i < n; i++) pulse_q.push_back({rand_pulse(), rand_pulse()});
    feeding = 1'b1;
    wait_drained();
  endtask

  initial begin
    in_if.valid = 1'b0; in_if.pulse_front = '0; in_if.pulse_back = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0; cfg_if.index = REG_TARGET; cfg_if.data = '0;
    m_target = 10000; m_kp = 2867; m_ki = 369; m_kd = 0; m_run = 0; m_manual = 0;
    w_pos = 0; w_fill = 0; integ_f = 0; integ_b = 0;
    prev_f = 0; prev_b = 0; held_f = 0; held_b = 0;
    foreach (win_f[i]) begin win_f[i] = 0; win_b[i] = 0; end
    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Directed: timeouts, over-long widths, extremes, manual drive.
    pulse_q.push_back({13'd0, 13'd0});
    pulse_q.push_back({13'd1, 13'd5000});
    pulse_q.push_back({13'd5001, 13'h1FFF});
    pulse_q.push_back({13'd1, 13'd1});
    feeding = 1'b1; wait_drained();
    reg_write(REG_MANUAL, 8'd255);
    pulse_q.push_back({13'd300, 13'd2500});
    feeding = 1'b1; wait_drained();
    reg_write(REG_RUN, 1);
    reg_write(REG_TARGET, 23'd5000000);
    reg_write(REG_PGAIN, 16'hFFFF);
    reg_write(REG_IGAIN, 16'hFFFF);
    reg_write(REG_DGAIN, 16'hFFFF);
    reg_write(3'd7, 23'h7FFFFF);   // unknown index, dropped
    for (int i = 0; i < 12; i++) pulse_q.push_back({13'd4000, 13'd1});
    feeding = 1'b1; wait_drained();
    reg_write(REG_TARGET, 0);
    for (int i = 0; i < 6; i++) pulse_q.push_back({13'd1, 13'd5000});
    feeding = 1'b1; wait_drained();

    // Random phases over a range of settings.
    for (int ph = 0; ph < 8; ph++) begin
      reg_write(REG_TARGET, ($urandom_range(3) == 0) ? $urandom_range(5000000) :
                $urandom_range(30000));
      reg_write(REG_PGAIN, $urandom_range(65535));
      reg_write(REG_IGAIN, (ph == 0) ? 0 : $urandom_range(65535));
      reg_write(REG_DGAIN, (ph == 1) ? 0 : $urandom_range(65535));
      reg_write(REG_RUN, (ph % 4) != 3);
      reg_write(REG_MANUAL, (ph == 7) ? 1 : $urandom_range(255));
      case (ph % 4)
        0: run_phase(80, 0, 0);
        1: run_phase(80, 79, 0);
        2: begin
          hold_req = ~hold_req;   // long hold-off while the sender keeps offering
          run_phase(80, 0, 79);
        end
        default: run_phase(80, 38, 38);
      endcase
    end

    repeat (600) @(posedge clk_i);
    if (errors == 0 && ctrl_q.size() == 0) begin
      $display("dual_motor_speed_pid_core regression: pass");
    end else begin
      $display("dual_motor_speed_pid_core regression: fail");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("dual_motor_speed_pid_core regression: fail");
    $finish;
  end
endmodule
